[src/bre_pkg.sv]
// Shared types, constants and the letter table for the button report encoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bre_pkg;

  localparam int MASK_W     = 12;  // width of one poll
  localparam int BYTE_W     = 8;   // width of a report byte
  localparam int LIDX_W     = 4;   // letter table index width (16 entries)
  localparam int CFG_IDX_W  = 2;   // configuration register index width
  localparam int QUEUE_DEPTH = 2;  // reports waiting between front and back

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd2;

  // Values after reset.
  localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'd18;
  localparam logic [BYTE_W-1:0] RST_END_BYTE   = 8'd19;
  localparam logic [BYTE_W-1:0] RST_SEP_BYTE   = 8'd44;

  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] separator_byte;
  } cfg_bytes_t;

  // Head of the report queue as the back end sees it.
  typedef struct packed {
    logic  valid;
    mask_t mask;
  } q_head_t;

  // Letter for one table index; the last four entries are unused and read zero.
  function automatic logic [BYTE_W-1:0] letter_of(input logic [LIDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = 8'h4A;  // J
      4'd1:    b = 8'h55;  // U
      4'd2:    b = 8'h32;  // 2
      4'd3:    b = 8'h31;  // 1
      4'd4:    b = 8'h57;  // W
      4'd5:    b = 8'h53;  // S
      4'd6:    b = 8'h41;  // A
      4'd7:    b = 8'h44;  // D
      4'd8:    b = 8'h4B;  // K
      4'd9:    b = 8'h49;  // I
      4'd10:   b = 8'h4C;  // L
      4'd11:   b = 8'h52;  // R
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[src/bre_front.sv]
// Front end: takes polls, masks off unused buttons and decides whether a report is due.
// Depends on bre_pkg.
`timescale 1ns / 1ps

module bre_front
  import bre_pkg::*;
#(
  parameter int BUTTON_COUNT = 12
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  mask_t pressed_mask,
  input  logic  q_full,
  output logic  in_stall,
  output logic  push,
  output mask_t push_mask
);

  logic  previous_nonzero;
  logic  accept;
  logic  nonzero;
  mask_t count_mask;

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      count_mask[i] = (i < BUTTON_COUNT);
    end
  end

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign push_mask = pressed_mask & count_mask;
  assign nonzero   = |push_mask;
  // A release after a press still needs an empty report.
  assign push      = accept && (nonzero || previous_nonzero);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_nonzero <= 1'b1;
    end else if (accept) begin
      previous_nonzero <= nonzero;
    end
  end

endmodule

[src/bre_queue.sv]
// Short report queue between the front and back ends.
// Depends on bre_pkg.
`timescale 1ns / 1ps

module bre_queue
  import bre_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  mask_t   push_mask,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mask_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.mask  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/bre_back.sv]
// Back end: walks one queued report and sends its bytes through an output register.
// Depends on bre_pkg.
`timescale 1ns / 1ps

module bre_back
  import bre_pkg::*;
#(
  parameter int BUTTON_COUNT = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_bytes_t        cfg,
  input  q_head_t           head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last_byte
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LETTER = 4'b0010,
    ST_SEP    = 4'b0100,
    ST_END    = 4'b1000
  } state_t;

  localparam logic [LIDX_W-1:0] IDX_TOP = LIDX_W'(BUTTON_COUNT - 1);

  state_t            state;
  state_t            state_next;
  mask_t             mask_r;
  mask_t             mask_next;
  mask_t             mask_left;
  logic [LIDX_W-1:0] low_k;
  logic              adv;
  logic              emit;
  logic [BYTE_W-1:0] byte_next;
  logic              last_next;

  // Lowest pressed button still to be sent.
  always_comb begin
    low_k = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_k = LIDX_W'(i);
      end
    end
  end

  assign mask_left = mask_r & (mask_r - 1'b1);
  assign adv       = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    mask_next  = mask_r;
    emit       = 1'b0;
    byte_next  = cfg.start_byte;
    last_next  = 1'b0;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          emit       = 1'b1;
          pop        = adv;
          mask_next  = head.mask;
          state_next = (head.mask != '0) ? ST_LETTER : ST_END;
        end
      end
      ST_LETTER: begin
        emit       = 1'b1;
        byte_next  = letter_of(IDX_TOP - low_k);
        mask_next  = mask_left;
        state_next = (mask_left != '0) ? ST_SEP : ST_END;
      end
      ST_SEP: begin
        emit       = 1'b1;
        byte_next  = cfg.separator_byte;
        state_next = ST_LETTER;
      end
      ST_END: begin
        emit       = 1'b1;
        byte_next  = cfg.end_byte;
        last_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else if (adv) begin
      state     <= state_next;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mask_r    <= mask_next;
      out_byte  <= byte_next;
      last_byte <= last_next;
    end
  end

endmodule

[src/button_report_encoder.sv]
// Top level of the button report encoder: configuration registers and the
// front end, report queue and back end. Depends on bre_pkg, bre_front, bre_queue, bre_back.
`timescale 1ns / 1ps
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -------------------------------
//  in        in_valid / in_stall       pressed_mask[11:0]
//  out       out_valid / out_stall     out_byte[7:0], last_byte
//  cfg       cfg_valid / cfg_ready     cfg_index[1:0], cfg_data[7:0]
//
// A report of n pressed buttons is 2n+1 beats long (start, letters with
// separators, end), 25 beats at most; a release report is two beats. The back
// end sends one beat per cycle while out_stall is low, and a poll that yields
// no report is taken at the input without a beat on the output.
// The front end takes a new poll whenever the two-entry report queue has room,
// so polls keep arriving while the back end still drains an earlier report.
// Reset is synchronous and active high; it restores the default start, end and
// separator bytes and marks the previous poll as nonzero. A stall on the output
// holds the current beat in the output register; once the queue fills, in_stall
// rises until the back end takes the next report.

module button_report_encoder
  import bre_pkg::*;
#(
  parameter int BUTTON_COUNT = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MASK_W-1:0]    pressed_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 last_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  cfg_bytes_t cfg;
  logic       q_full;
  logic       push;
  mask_t      push_mask;
  logic       pop;
  q_head_t    head;

  // Registers take a write on any cycle; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte     <= RST_START_BYTE;
      cfg.end_byte       <= RST_END_BYTE;
      cfg.separator_byte <= RST_SEP_BYTE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START: cfg.start_byte     <= cfg_data;
        CFG_END:   cfg.end_byte       <= cfg_data;
        CFG_SEP:   cfg.separator_byte <= cfg_data;
        default:   ;
      endcase
    end
  end

  // The front end decides per poll whether a report is due and queues its mask.
  bre_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .pressed_mask(pressed_mask),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .push        (push),
    .push_mask   (push_mask)
  );

  bre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_mask(push_mask),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // The back end turns a queued mask into report bytes, one per cycle while
  // out_stall is low. An empty mask yields just the start and end bytes.
  bre_back #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .last_byte(last_byte)
  );

endmodule
